[hdl/bcc_pkg.sv]
// Shared widths, register map, reset values and history patterns of the
// button click classifier. No dependencies.
`default_nettype none

package bcc_pkg;

	// Tick counter and threshold width.
	localparam int CNT_W = 10;
	// Sample history length, newest sample in bit 0.
	localparam int HIST_W = 4;
	// Width of the remainder sequencer's step counter, one bit of the counter per step.
	localparam int STEP_W = $clog2(CNT_W + 1);

	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACTIVE_LEVEL  = 3'd0,
		REG_PRESS_CONFIRM = 3'd1,
		REG_HOLD_LIMIT    = 3'd2,
		REG_DOUBLE_WINDOW = 3'd3,
		REG_REPEAT_PERIOD = 3'd4,
		REG_SINGLE_EN     = 3'd5,
		REG_DOUBLE_EN     = 3'd6,
		REG_UNUSED        = 3'd7
	} reg_idx_t;

	localparam logic              RST_ACTIVE_LEVEL  = 1'b1;
	localparam logic [CNT_W-1:0]  RST_PRESS_CONFIRM = CNT_W'(4);
	localparam logic [CNT_W-1:0]  RST_HOLD_LIMIT    = CNT_W'(100);
	localparam logic [CNT_W-1:0]  RST_DOUBLE_WINDOW = CNT_W'(30);
	localparam logic [CNT_W-1:0]  RST_REPEAT_PERIOD = CNT_W'(20);
	localparam logic              RST_SINGLE_EN     = 1'b1;
	localparam logic              RST_DOUBLE_EN     = 1'b1;

	// Two pressed samples after two released ones, and the reverse.
	localparam logic [HIST_W-1:0] PAT_PRESS   = 4'b0011;
	localparam logic [HIST_W-1:0] PAT_RELEASE = 4'b1100;

	// Configuration as seen by the classifier logic.
	typedef struct packed {
		logic             active_level;
		logic [CNT_W-1:0] press_confirm;
		logic [CNT_W-1:0] hold_limit;
		logic [CNT_W-1:0] double_window;
		logic [CNT_W-1:0] repeat_period;
		logic             single_en;
		logic             double_en;
	} cfg_t;

endpackage

`default_nettype wire

[hdl/button_click_classifier_top.sv]
// Top level of the button click classifier: APB register file, input stage,
// click state machine, result register and counter remainder sequencer.
// Depends on bcc_pkg.
`default_nettype none

//  Channel   Handshake                   Payload
//  pin       pin_valid / pin_stall       pin_level
//  result    result_valid / result_stall single_clicks, double_click, fsm_state
//  config    APB psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One beat is accepted per clock while pin_stall is low; each beat is captured
// in the input register at its accepting edge and passes from there through the
// state machine into the result register. A stalled result holds, and the input
// side keeps accepting until the input register is also occupied.
// Writing repeat_period while a long press is in progress reduces the tick
// counter modulo the new period one bit per cycle, and pin_stall is held high
// until the reduction is done. Reset clears all control state and restores
// the register defaults.

module button_click_classifier_top (
	input  wire                            clk,
	input  wire                            arst_n,

	input  wire                            pin_valid,
	output logic                           pin_stall,
	input  wire                            pin_level,

	output logic                           result_valid,
	input  wire                            result_stall,
	output logic [1:0]                     single_clicks,
	output logic                           double_click,
	output logic [2:0]                     fsm_state,

	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [bcc_pkg::APB_AW-1:0]     paddr,
	input  wire  [bcc_pkg::APB_DW-1:0]     pwdata,
	output logic [bcc_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_CONFIRM = 3'd1,
		ST_PRELONG = 3'd2,
		ST_WAIT2   = 3'd3,
		ST_SINGLE  = 3'd4,
		ST_DOUBLE  = 3'd5,
		ST_LONG    = 3'd6
	} state_t;

	localparam int CW = bcc_pkg::CNT_W;

	// ---------------- configuration registers ----------------
	bcc_pkg::cfg_t     cfg_q;
	bcc_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;
	logic [CW-1:0]     period_eff;

	assign pready  = 1'b1;
	assign reg_idx = bcc_pkg::reg_idx_t'(paddr[bcc_pkg::APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level  <= bcc_pkg::RST_ACTIVE_LEVEL;
			cfg_q.press_confirm <= bcc_pkg::RST_PRESS_CONFIRM;
			cfg_q.hold_limit    <= bcc_pkg::RST_HOLD_LIMIT;
			cfg_q.double_window <= bcc_pkg::RST_DOUBLE_WINDOW;
			cfg_q.repeat_period <= bcc_pkg::RST_REPEAT_PERIOD;
			cfg_q.single_en     <= bcc_pkg::RST_SINGLE_EN;
			cfg_q.double_en     <= bcc_pkg::RST_DOUBLE_EN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bcc_pkg::REG_ACTIVE_LEVEL:  cfg_q.active_level  <= pwdata[0];
				bcc_pkg::REG_PRESS_CONFIRM: cfg_q.press_confirm <= pwdata[CW-1:0];
				bcc_pkg::REG_HOLD_LIMIT:    cfg_q.hold_limit    <= pwdata[CW-1:0];
				bcc_pkg::REG_DOUBLE_WINDOW: cfg_q.double_window <= pwdata[CW-1:0];
				bcc_pkg::REG_REPEAT_PERIOD: cfg_q.repeat_period <= pwdata[CW-1:0];
				bcc_pkg::REG_SINGLE_EN:     cfg_q.single_en     <= pwdata[0];
				bcc_pkg::REG_DOUBLE_EN:     cfg_q.double_en     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			bcc_pkg::REG_ACTIVE_LEVEL:  prdata = bcc_pkg::APB_DW'(cfg_q.active_level);
			bcc_pkg::REG_PRESS_CONFIRM: prdata = bcc_pkg::APB_DW'(cfg_q.press_confirm);
			bcc_pkg::REG_HOLD_LIMIT:    prdata = bcc_pkg::APB_DW'(cfg_q.hold_limit);
			bcc_pkg::REG_DOUBLE_WINDOW: prdata = bcc_pkg::APB_DW'(cfg_q.double_window);
			bcc_pkg::REG_REPEAT_PERIOD: prdata = bcc_pkg::APB_DW'(cfg_q.repeat_period);
			bcc_pkg::REG_SINGLE_EN:     prdata = bcc_pkg::APB_DW'(cfg_q.single_en);
			bcc_pkg::REG_DOUBLE_EN:     prdata = bcc_pkg::APB_DW'(cfg_q.double_en);
			default:                    prdata = '0;
		endcase
	end

	// A period of zero behaves as a period of one.
	assign period_eff = (cfg_q.repeat_period == '0) ? CW'(1) : cfg_q.repeat_period;

	// ---------------- pipeline control ----------------
	logic   valid_s1;
	logic   pin_s1;
	logic   out_valid_q;
	logic   advance;
	logic   busy_q;
	logic   rem_done;
	state_t state_q;
	logic [CW-1:0] tick_q;
	logic [CW-1:0] rem_n;

	assign advance   = valid_s1 && (!out_valid_q || !result_stall);
	assign pin_stall = busy_q || (valid_s1 && !advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pin_s1   <= 1'b0;
		end else begin
			if (pin_valid && !pin_stall) begin
				valid_s1 <= 1'b1;
				pin_s1   <= pin_level;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// ---------------- remainder sequencer ----------------
	// Restoring remainder of the tick counter by the new period, MSB first.
	logic [bcc_pkg::STEP_W-1:0] step_q;
	logic [CW-1:0]              div_q;
	logic [CW-1:0]              rem_q;
	logic [CW:0]                trial;

	assign trial    = {rem_q, div_q[CW-1]};
	assign rem_n    = (trial >= {1'b0, period_eff}) ? CW'(trial - {1'b0, period_eff})
	                                                : trial[CW-1:0];
	assign rem_done = busy_q && (step_q == bcc_pkg::STEP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else if (cfg_wr && reg_idx == bcc_pkg::REG_REPEAT_PERIOD
				&& state_q == ST_LONG) begin
			busy_q <= 1'b1;
			step_q <= bcc_pkg::STEP_W'(CW);
			div_q  <= tick_q;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			div_q  <= {div_q[CW-2:0], 1'b0};
			step_q <= step_q - bcc_pkg::STEP_W'(1);
			if (rem_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// ---------------- click state machine ----------------
	logic [bcc_pkg::HIST_W-1:0] hist_q;
	logic [bcc_pkg::HIST_W-1:0] hist_n;
	logic                       press;
	logic                       release_ev;
	state_t                     state_n;
	logic [CW-1:0]              tick_n;
	logic [1:0]                 singles_n;
	logic                       dbl_n;
	logic [1:0]                 singles_q;
	logic                       dbl_q;
	state_t                     fsm_out_q;

	assign hist_n     = {hist_q[bcc_pkg::HIST_W-2:0], pin_s1 == cfg_q.active_level};
	assign press      = hist_n == bcc_pkg::PAT_PRESS;
	assign release_ev = hist_n == bcc_pkg::PAT_RELEASE;

	always_comb begin
		state_n   = state_q;
		tick_n    = tick_q;
		singles_n = 2'd0;
		dbl_n     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (press) begin
					state_n = ST_CONFIRM;
					tick_n  = '0;
				end
			end
			ST_CONFIRM: begin
				if (tick_q < cfg_q.press_confirm) begin
					if (release_ev) begin
						state_n = ST_WAIT2;
						tick_n  = '0;
					end else begin
						tick_n = tick_q + CW'(1);
					end
				end else begin
					state_n = ST_PRELONG;
					tick_n  = '0;
				end
			end
			ST_PRELONG: begin
				if (tick_q < cfg_q.hold_limit) begin
					if (release_ev) begin
						state_n = ST_WAIT2;
						tick_n  = '0;
					end else begin
						tick_n = tick_q + CW'(1);
					end
				end else begin
					state_n = ST_LONG;
					tick_n  = '0;
				end
			end
			ST_WAIT2: begin
				if (tick_q < cfg_q.double_window) begin
					if (press) begin
						state_n = ST_DOUBLE;
						tick_n  = '0;
					end else begin
						tick_n = tick_q + CW'(1);
					end
				end else begin
					state_n = ST_SINGLE;
					tick_n  = '0;
				end
			end
			ST_SINGLE: begin
				singles_n = cfg_q.single_en ? 2'd1 : 2'd0;
				state_n   = ST_IDLE;
			end
			ST_DOUBLE: begin
				if (cfg_q.double_en) begin
					dbl_n = 1'b1;
				end else if (cfg_q.single_en) begin
					singles_n = 2'd2;
				end
				state_n = ST_IDLE;
			end
			ST_LONG: begin
				// The counter is kept below the period, so no reduction is needed here.
				if (release_ev) begin
					state_n = ST_IDLE;
					tick_n  = '0;
				end else begin
					singles_n = (tick_q == '0 && cfg_q.single_en) ? 2'd1 : 2'd0;
					tick_n    = (tick_q == period_eff - CW'(1)) ? '0 : tick_q + CW'(1);
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			hist_q      <= '0;
			out_valid_q <= 1'b0;
			singles_q   <= 2'd0;
			dbl_q       <= 1'b0;
			fsm_out_q   <= ST_IDLE;
		end else begin
			if (rem_done) begin
				tick_q <= rem_n;
			end else if (advance) begin
				tick_q <= tick_n;
			end
			if (advance) begin
				state_q     <= state_n;
				hist_q      <= hist_n;
				out_valid_q <= 1'b1;
				singles_q   <= singles_n;
				dbl_q       <= dbl_n;
				fsm_out_q   <= state_n;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign single_clicks = singles_q;
	assign double_click  = dbl_q;
	assign fsm_state     = fsm_out_q;

	// ---------------- assertions ----------------
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pin_stall)
		else $error("input accepted while the counter is being reduced");

	a_long_counter_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LONG && !busy_q) |-> (tick_q < period_eff))
		else $error("long press counter not below the repeat period");

	a_double_excludes_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && double_click) |-> (single_clicks == 2'd0))
		else $error("double click reported together with single clicks");

	a_report_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (double_click || single_clicks == 2'd2))
			|-> (fsm_state == ST_IDLE))
		else $error("double report without a return to idle");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the button click classifier: pin beats and APB
// register writes go in, and a scoreboard class predicts every result beat.
// Depends on bcc_pkg and button_click_classifier_top.

module testbench;

	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int PRESSURE_CYCLES = 40;
	localparam int BEATS_PER_SETTING = 205;
	localparam int HOLD_CAP = 120;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_CONFIRM = 3'd1,
		ST_PRELONG = 3'd2,
		ST_WAIT2   = 3'd3,
		ST_SINGLE  = 3'd4,
		ST_DOUBLE  = 3'd5,
		ST_LONG    = 3'd6,
		ST_UNUSED  = 3'd7
	} click_state_t;

	typedef struct packed {
		logic [1:0]   singles;
		logic         dbl;
		click_state_t state;
	} click_result_t;

	class click_scoreboard;
		logic                      active_level;
		logic [bcc_pkg::CNT_W-1:0] confirm_ticks;
		logic [bcc_pkg::CNT_W-1:0] long_ticks;
		logic [bcc_pkg::CNT_W-1:0] window_ticks;
		logic [bcc_pkg::CNT_W-1:0] period_ticks;
		logic                      single_en;
		logic                      double_en;

		logic [bcc_pkg::HIST_W-1:0] history;
		click_state_t               state;
		logic [bcc_pkg::CNT_W-1:0]  ticks;

		click_result_t pending[$];
		int errors;

		function new();
			active_level  = bcc_pkg::RST_ACTIVE_LEVEL;
			confirm_ticks = bcc_pkg::RST_PRESS_CONFIRM;
			long_ticks    = bcc_pkg::RST_HOLD_LIMIT;
			window_ticks  = bcc_pkg::RST_DOUBLE_WINDOW;
			period_ticks  = bcc_pkg::RST_REPEAT_PERIOD;
			single_en     = bcc_pkg::RST_SINGLE_EN;
			double_en     = bcc_pkg::RST_DOUBLE_EN;
			history = '0;
			state   = ST_IDLE;
			ticks   = '0;
			errors  = 0;
		endfunction

		function void write_reg(input bcc_pkg::reg_idx_t idx,
				input logic [bcc_pkg::APB_DW-1:0] data);
			case (idx)
				bcc_pkg::REG_ACTIVE_LEVEL:  active_level  = data[0];
				bcc_pkg::REG_PRESS_CONFIRM: confirm_ticks = data[bcc_pkg::CNT_W-1:0];
				bcc_pkg::REG_HOLD_LIMIT:    long_ticks    = data[bcc_pkg::CNT_W-1:0];
				bcc_pkg::REG_DOUBLE_WINDOW: window_ticks  = data[bcc_pkg::CNT_W-1:0];
				bcc_pkg::REG_REPEAT_PERIOD: period_ticks  = data[bcc_pkg::CNT_W-1:0];
				bcc_pkg::REG_SINGLE_EN:     single_en     = data[0];
				bcc_pkg::REG_DOUBLE_EN:     double_en     = data[0];
				default: ;
			endcase
		endfunction

		// Advances the click state machine by one pin beat and queues its result.
		function void note_pin(input logic lvl);
			logic          press_ev;
			logic          release_ev;
			int            period;
			int            rem;
			click_result_t res;
			res = '0;
			period = (period_ticks == '0) ? 1 : int'(period_ticks);
			history = {history[bcc_pkg::HIST_W-2:0], lvl == active_level};
			press_ev = (history == bcc_pkg::PAT_PRESS);
			release_ev = (history == bcc_pkg::PAT_RELEASE);
			case (state)
				ST_IDLE: begin
					if (press_ev) begin
						state = ST_CONFIRM;
						ticks = '0;
					end
				end
				ST_CONFIRM: begin
					if (ticks < confirm_ticks) begin
						if (release_ev) begin
							state = ST_WAIT2;
							ticks = '0;
						end else begin
							ticks = ticks + 1'b1;
						end
					end else begin
						state = ST_PRELONG;
						ticks = '0;
					end
				end
				ST_PRELONG: begin
					if (ticks < long_ticks) begin
						if (release_ev) begin
							state = ST_WAIT2;
							ticks = '0;
						end else begin
							ticks = ticks + 1'b1;
						end
					end else begin
						state = ST_LONG;
						ticks = '0;
					end
				end
				ST_WAIT2: begin
					if (ticks < window_ticks) begin
						if (press_ev) begin
							state = ST_DOUBLE;
							ticks = '0;
						end else begin
							ticks = ticks + 1'b1;
						end
					end else begin
						state = ST_SINGLE;
						ticks = '0;
					end
				end
				ST_SINGLE: begin
					if (single_en)
						res.singles = 2'd1;
					state = ST_IDLE;
				end
				ST_DOUBLE: begin
					if (double_en)
						res.dbl = 1'b1;
					else if (single_en)
						res.singles = 2'd2;
					state = ST_IDLE;
				end
				ST_LONG: begin
					if (release_ev) begin
						state = ST_IDLE;
						ticks = '0;
					end else begin
						// The counter is taken modulo the current period, so a
						// period written mid-press applies at once.
						rem = int'(ticks) % period;
						if (rem == 0 && single_en)
							res.singles = 2'd1;
						ticks = bcc_pkg::CNT_W'((rem + 1) % period);
					end
				end
				default: state = ST_IDLE;
			endcase
			res.state = state;
			pending.push_back(res);
		endfunction

		task report_mismatch(input string what);
			errors++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_result(input logic [1:0] singles, input logic dbl, input logic [2:0] st);
			click_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("result beat with no expected result waiting");
				return;
			end
			want = pending.pop_front();
			if (singles !== want.singles)
				report_mismatch($sformatf("single_clicks %0d, expected %0d", singles,
					want.singles));
			if (dbl !== want.dbl)
				report_mismatch($sformatf("double_click %0d, expected %0d", dbl, want.dbl));
			if (st !== want.state)
				report_mismatch($sformatf("fsm_state %0d, expected %0d", st, want.state));
		endtask

		task report_leftovers();
			if (pending.size() != 0)
				report_mismatch($sformatf("%0d expected results never arrived",
					pending.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic        pin_valid;
	logic        pin_stall;
	logic        pin_level;

	logic        result_valid;
	logic        result_stall;
	logic [1:0]  single_clicks;
	logic        double_click;
	logic [2:0]  fsm_state;

	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bcc_pkg::APB_AW-1:0] paddr;
	logic [bcc_pkg::APB_DW-1:0] pwdata;
	logic [bcc_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	click_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int beats_sent;
	int hold_left;
	int quiet_cycles;
	bit hold_pending = 1'b0;

	button_click_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pin_valid    (pin_valid),
		.pin_stall    (pin_stall),
		.pin_level    (pin_level),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.single_clicks(single_clicks),
		.double_click (double_click),
		.fsm_state    (fsm_state),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	// Result side: random stall, plus one long hold-off on request.
	initial begin
		result_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(single_clicks, double_click, fsm_state);
	end

	always @(posedge clk) begin
		if ((pin_valid && pin_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)
				|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Entered and left at a falling edge; valid stays high on return.
	task automatic send_pin(input logic lvl);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pin_valid <= 1'b0;
			@(negedge clk);
		end
		pin_valid <= 1'b1;
		pin_level <= lvl;
		@(posedge clk);
		while (pin_stall)
			@(posedge clk);
		sb.note_pin(lvl);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_active(input logic act, input int count);
		repeat (count)
			send_pin(act ? sb.active_level : ~sb.active_level);
	endtask

	task automatic wait_drained();
		pin_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input bcc_pkg::reg_idx_t idx, input int unsigned value);
		logic [bcc_pkg::APB_DW-1:0] data;
		data = ($urandom() << bcc_pkg::CNT_W) | (value & ((1 << bcc_pkg::CNT_W) - 1));
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int pick_threshold(input int hi);
		int r;
		r = $urandom_range(0, 11);
		if (r == 0)
			return 0;
		if (r == 1)
			return (1 << bcc_pkg::CNT_W) - 1;
		return $urandom_range(1, hi);
	endfunction

	task automatic randomise_config();
		cfg_write(bcc_pkg::REG_ACTIVE_LEVEL, $urandom_range(0, 1));
		cfg_write(bcc_pkg::REG_PRESS_CONFIRM, pick_threshold(8));
		cfg_write(bcc_pkg::REG_HOLD_LIMIT, pick_threshold(25));
		cfg_write(bcc_pkg::REG_DOUBLE_WINDOW, pick_threshold(12));
		cfg_write(bcc_pkg::REG_REPEAT_PERIOD, pick_threshold(8));
		cfg_write(bcc_pkg::REG_SINGLE_EN, $urandom_range(0, 3) != 0);
		cfg_write(bcc_pkg::REG_DOUBLE_EN, $urandom_range(0, 3) != 0);
	endtask

	// Mostly whole presses sized around the thresholds, with some noise.
	task automatic run_random(input int count);
		int stop_at;
		int hold;
		int gap;
		int conf;
		int lng;
		int win;
		int per;
		int r;
		stop_at = beats_sent + count;
		conf = int'(sb.confirm_ticks);
		lng = int'(sb.long_ticks);
		win = int'(sb.window_ticks);
		per = (sb.period_ticks == '0) ? 1 : int'(sb.period_ticks);
		while (beats_sent < stop_at) begin
			r = $urandom_range(0, 7);
			if (r == 0) begin
				repeat ($urandom_range(1, 6))
					send_pin(1'($urandom_range(0, 1)));
			end else begin
				if (r < 3)
					hold = $urandom_range(2, conf + 3);
				else if (r < 5)
					hold = $urandom_range(conf + 2, conf + lng + 4);
				else
					hold = conf + lng + 3 + $urandom_range(0, 3 * per + 3);
				if ($urandom_range(0, 1))
					gap = $urandom_range(2, win + 2);
				else
					gap = win + 3 + $urandom_range(0, 6);
				if (hold > HOLD_CAP)
					hold = HOLD_CAP;
				if (gap > HOLD_CAP)
					gap = HOLD_CAP;
				send_active(1'b1, hold);
				send_active(1'b0, gap);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		pin_valid = 1'b0;
		pin_level = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		beats_sent = 0;
		quiet_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero thresholds and a zero period, pressed level low: each threshold state
		// leaves at once and the long press repeats on every tick.
		cfg_write(bcc_pkg::REG_ACTIVE_LEVEL, 0);
		cfg_write(bcc_pkg::REG_PRESS_CONFIRM, 0);
		cfg_write(bcc_pkg::REG_HOLD_LIMIT, 0);
		cfg_write(bcc_pkg::REG_DOUBLE_WINDOW, 0);
		cfg_write(bcc_pkg::REG_REPEAT_PERIOD, 0);
		send_active(1'b0, 1);
		send_active(1'b1, 5);
		send_active(1'b0, 2);
		wait_drained();

		// Every threshold at its top and both handlers absent, so a double
		// click reports nothing at all.
		cfg_write(bcc_pkg::REG_ACTIVE_LEVEL, 1);
		cfg_write(bcc_pkg::REG_PRESS_CONFIRM, 1023);
		cfg_write(bcc_pkg::REG_HOLD_LIMIT, 1023);
		cfg_write(bcc_pkg::REG_DOUBLE_WINDOW, 1023);
		cfg_write(bcc_pkg::REG_REPEAT_PERIOD, 1023);
		cfg_write(bcc_pkg::REG_SINGLE_EN, 0);
		cfg_write(bcc_pkg::REG_DOUBLE_EN, 0);
		send_active(1'b1, 2);
		send_active(1'b0, 2);
		send_active(1'b1, 2);
		send_active(1'b0, 2);
		wait_drained();

		// A write beyond the register list must change nothing.
		cfg_write(bcc_pkg::REG_UNUSED, $urandom());
		cfg_write(bcc_pkg::REG_SINGLE_EN, 1);
		cfg_write(bcc_pkg::REG_DOUBLE_EN, 1);
		cfg_write(bcc_pkg::REG_PRESS_CONFIRM, 0);
		cfg_write(bcc_pkg::REG_HOLD_LIMIT, 0);
		cfg_write(bcc_pkg::REG_REPEAT_PERIOD, 4);
		send_active(1'b1, 6);
		wait_drained();
		// Shorten the period while the long press is still held.
		cfg_write(bcc_pkg::REG_REPEAT_PERIOD, 3);
		send_active(1'b1, 4);
		send_active(1'b0, 3);

		for (int mode = 0; mode < 3; mode++) begin
			for (int k = 0; k < 3; k++) begin
				wait_drained();
				tx_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 52 : 0;
				rx_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 21 : 0;
				randomise_config();
				if (mode == 2 && k == 0) begin
					@(posedge clk);
					hold_pending = 1'b1;
					@(negedge clk);
				end
				run_random(BEATS_PER_SETTING);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
hdl/bcc_pkg.sv
hdl/button_click_classifier_top.sv
bench/testbench.sv
